### hw/rtl/tlve_pkg.sv
// Shared types and constants for the TLV record value extractor.
`default_nettype none

package tlve_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned RegIdxW = 1;
  localparam int unsigned RegW    = 16;

  // Register indexes of the configuration port
  localparam logic [RegIdxW-1:0] REG_SEARCH_CODE = 1'b0;
  localparam logic [RegIdxW-1:0] REG_COPY_LIMIT  = 1'b1;

  localparam logic [ByteW-1:0]  SEARCH_CODE_RST = 8'd1;
  localparam logic [LimitW-1:0] COPY_LIMIT_RST  = 16'd255;

  typedef enum logic [2:0] {
    PH_CODE      = 3'd0,
    PH_MATCH_LEN = 3'd1,
    PH_OTHER_LEN = 3'd2,
    PH_COPY      = 3'd3,
    PH_SKIP      = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    OC_SCAN      = 3'd0,
    OC_FOUND     = 3'd1,
    OC_NOT_FOUND = 3'd2,
    OC_BAD       = 3'd3,
    OC_IGNORED   = 3'd4
  } outcome_t;

  typedef struct packed {
    phase_t            phase;
    logic [ByteW-1:0]  rec_left;
    logic [LimitW-1:0] copy_left;
    logic              finished;
  } scan_state_t;

  typedef struct packed {
    logic [ByteW-1:0]  search_code;
    logic [LimitW-1:0] copy_limit;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] value_byte;
    logic             value_valid;
    outcome_t         outcome;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/tlve_if.sv
// Valid/ready channel interfaces for buffer bytes and extracted results.
`default_nettype none

interface tlve_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] buffer_byte;
  logic       buffer_end;

  modport source (output valid, output buffer_byte, output buffer_end, input ready);
  modport sink   (input valid, input buffer_byte, input buffer_end, output ready);
endinterface

interface tlve_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       value_valid;
  logic [2:0] outcome;

  modport source (output valid, output value_byte, output value_valid, output outcome,
                  input ready);
  modport sink   (input valid, input value_byte, input value_valid, input outcome,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/tlve_cfg_regs.sv
// Configuration registers: search code and copy limit.
`default_nettype none

module tlve_cfg_regs
  import tlve_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [RegIdxW-1:0] wr_index,
  input  wire logic [RegW-1:0]    wr_data,
  output cfg_t                    cfg
);

  // Decode writes by register index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_code <= SEARCH_CODE_RST;
      cfg.copy_limit  <= COPY_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_SEARCH_CODE: cfg.search_code <= wr_data[ByteW-1:0];
        REG_COPY_LIMIT:  cfg.copy_limit  <= wr_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tlve_step.sv
// Per-byte scan logic: next scan state and the result for one buffer byte.
`default_nettype none

module tlve_step
  import tlve_pkg::*;
(
  input  wire cfg_t        cfg,
  input  wire scan_state_t state,
  input  wire logic [ByteW-1:0] buffer_byte,
  input  wire logic        buffer_end,
  output scan_state_t      state_next,
  output result_t          result
);

  scan_state_t      st;
  outcome_t         oc;
  logic [ByteW-1:0] vb;
  logic             vv;

  always_comb begin
    st = state;
    oc = OC_SCAN;
    vb = '0;
    vv = 1'b0;

    if (state.finished) begin
      oc = OC_IGNORED;
    end else begin
      case (state.phase)
        PH_CODE: begin
          if (cfg.search_code == '0) begin
            oc = OC_BAD;
          end else if (buffer_byte == '0) begin
            oc = OC_NOT_FOUND;
          end else begin
            st.phase = (buffer_byte == cfg.search_code) ? PH_MATCH_LEN : PH_OTHER_LEN;
          end
        end
        PH_MATCH_LEN: begin
          if (buffer_byte == '0) begin
            oc = OC_FOUND;
          end else begin
            st.rec_left  = buffer_byte;
            st.copy_left = cfg.copy_limit;
            st.phase     = PH_COPY;
          end
        end
        PH_OTHER_LEN: begin
          if (buffer_byte == '0) begin
            st.phase = PH_CODE;
          end else begin
            st.rec_left = buffer_byte;
            st.phase    = PH_SKIP;
          end
        end
        PH_COPY: begin
          // Hand out the byte while both counts allow it
          if (state.copy_left != '0 && state.rec_left != '0) begin
            vb           = buffer_byte;
            vv           = 1'b1;
            st.copy_left = state.copy_left - 1'b1;
            st.rec_left  = state.rec_left - 1'b1;
            if (state.copy_left == LimitW'(1)) begin
              oc = OC_FOUND;
            end
          end else begin
            oc = OC_FOUND;
          end
        end
        PH_SKIP: begin
          if (state.rec_left != '0) begin
            st.rec_left = state.rec_left - 1'b1;
          end
          if (state.rec_left <= ByteW'(1)) begin
            st.phase = PH_CODE;
          end
        end
        default: begin
          st.phase = PH_CODE;
        end
      endcase
      if (oc != OC_SCAN) begin
        st.finished = 1'b1;
      end
    end

    // Rearm on the last byte of the buffer
    if (buffer_end) begin
      if (oc == OC_SCAN) begin
        oc = OC_NOT_FOUND;
      end
      st.phase     = PH_CODE;
      st.rec_left  = '0;
      st.copy_left = cfg.copy_limit;
      st.finished  = 1'b0;
    end

    state_next         = st;
    result.value_byte  = vb;
    result.value_valid = vv;
    result.outcome     = oc;
  end

endmodule

`default_nettype wire

### hw/rtl/tlv_record_value_extractor_top.sv
// Top level of the TLV record value extractor: input register, scan state, result register.
// Path: a byte accepted into the input register moves into the result register, which
//   presents its result; a full result register that is not drained holds the byte back.
// Throughput: one buffer byte per cycle unless results.ready stalls; scan state updates as
//   a byte moves from input to result register, so consecutive bytes follow back to back.
// Reset (rst, synchronous): both registers empty, scan state at expect-code, search
//   code 1, copy limit 255.
`default_nettype none

module tlv_record_value_extractor_top
  import tlve_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [RegIdxW-1:0] wr_index,
  input  wire logic [RegW-1:0]    wr_data,
  tlve_byte_if.sink               bytes,
  tlve_result_if.source           results
);

  cfg_t             cfg;
  scan_state_t      state;
  scan_state_t      state_next;
  result_t          step_result;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_end;

  logic             res_valid;
  result_t          res;

  logic             res_free;
  logic             advance;

  tlve_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  tlve_step u_step (
    .cfg         (cfg),
    .state       (state),
    .buffer_byte (in_byte),
    .buffer_end  (in_end),
    .state_next  (state_next),
    .result      (step_result)
  );

  // Move the held byte on when the result register is empty or being drained
  assign res_free    = !res_valid || results.ready;
  assign advance     = in_valid && res_free;
  assign bytes.ready = !in_valid || res_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      in_byte <= bytes.buffer_byte;
      in_end  <= bytes.buffer_end;
    end
  end

  // Scan state, updated once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_CODE;
      state.rec_left  <= '0;
      state.copy_left <= COPY_LIMIT_RST;
      state.finished  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_result;
    end
  end

  assign results.valid       = res_valid;
  assign results.value_byte  = res.value_byte;
  assign results.value_valid = res.value_valid;
  assign results.outcome     = res.outcome;

  // Checks on the scan logic
  a_ignored_no_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.outcome == OC_IGNORED |-> !res.value_valid)
    else $error("ignored byte carries a value");

  a_value_outcome: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.value_valid |->
      res.outcome == OC_SCAN || res.outcome == OC_FOUND || res.outcome == OC_NOT_FOUND)
    else $error("value byte with impossible outcome");

  a_rearm_on_end: assert property (@(posedge clk) disable iff (rst)
    advance && in_end |=> state.phase == PH_CODE && !state.finished && state.rec_left == '0)
    else $error("scan state not rearmed after buffer end");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_valid && !res_free |=> in_valid && $stable(in_byte) && $stable(in_end)
      && $stable(state))
    else $error("held byte or scan state changed while blocked");

  a_finished_reports: assert property (@(posedge clk) disable iff (rst)
    advance && !state.finished && state_next.finished |-> step_result.outcome != OC_SCAN)
    else $error("search finished without a final outcome");

endmodule

`default_nettype wire
